// ===== hdl/shbd_pkg.sv =====
// shared constants, types and functions of the static huffman byte decoder
// the node table is a constant built at elaboration from the frequency table
// no dependencies
package shbd_pkg;

   localparam int SYMBOL_COUNT = 31;
   localparam int INNER_COUNT  = SYMBOL_COUNT - 1;
   localparam int SYM_W        = $clog2(SYMBOL_COUNT);
   localparam int NODE_W       = (INNER_COUNT > 1) ? $clog2(INNER_COUNT) : 1;
   localparam int CODE_W       = SYM_W + 1;
   localparam int LEAF_MARK    = 'h80;
   localparam int CODE_MASK    = 127;
   localparam int TERM_SYMBOL  = 27;

   localparam int BYTE_W       = 8;
   localparam int SYMBOL_W     = 5;
   localparam int CHAR_W       = 8;
   localparam int REQ_TDATA_W  = 8;
   localparam int RSP_TDATA_W  = 16;
   localparam int RSP_PAD_W    = RSP_TDATA_W - SYMBOL_W - CHAR_W;
   localparam int BIT_CNT_W    = $clog2(BYTE_W);

   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   typedef logic [INNER_COUNT-1:0][2*CODE_W-1:0] node_table_type;
   typedef logic [SYM_W-1:0] sym_type;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data_byte;
   } queue_head_type;

   localparam int FREQ_TABLE [64] = '{
      81, 15, 28, 43, 128, 23, 20, 61, 71, 2, 1, 40, 24, 69, 76, 20,
      1, 61, 64, 91, 28, 10, 24, 1, 20, 1, 130, 80, 80, 5, 80, 1,
      1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1,
      1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1
   };

   // leaf flag on top, symbol or inner node index below
   function automatic logic [CODE_W-1:0] encode_code(int code);
      logic leaf;
      leaf = (code >= LEAF_MARK);
      return {leaf, SYM_W'(code & CODE_MASK)};
   endfunction

   // merge rule: first strict minimum twice (left, right), parent pushed at head
   function automatic node_table_type build_tree();
      int             code [SYMBOL_COUNT];
      int             freq [SYMBOL_COUNT];
      int             pick_code [2];
      int             pick_freq [2];
      int             len;
      int             best;
      node_table_type t;
      t = '0;
      for (int i = 0; i < SYMBOL_COUNT; i++) begin
         code[i] = LEAF_MARK | i;
         freq[i] = FREQ_TABLE[i & 63];
      end
      len = SYMBOL_COUNT;
      for (int k = 0; k < INNER_COUNT; k++) begin
         for (int p = 0; p < 2; p++) begin
            best = 0;
            for (int j = 1; j < len; j++) begin
               if (freq[j] < freq[best]) best = j;
            end
            pick_code[p] = code[best];
            pick_freq[p] = freq[best];
            for (int j = best; j < len - 1; j++) begin
               code[j] = code[j+1];
               freq[j] = freq[j+1];
            end
            len--;
         end
         for (int j = len; j > 0; j--) begin
            code[j] = code[j-1];
            freq[j] = freq[j-1];
         end
         code[0] = k;
         freq[0] = pick_freq[0] + pick_freq[1];
         len++;
         t[k] = {encode_code(pick_code[1]), encode_code(pick_code[0])};
      end
      return t;
   endfunction

   localparam node_table_type NODE_TABLE = build_tree();
   localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(INNER_COUNT - 1);

   function automatic logic [CHAR_W-1:0] char_of(sym_type sym);
      int s;
      s = int'(sym);
      if (s <= 25) return CHAR_W'(97 + s);
      if (s == 26) return CHAR_W'(32);
      if (s == 28) return CHAR_W'(10);
      if (s == 29) return CHAR_W'(96);
      return '0;
   endfunction

   function automatic logic is_end_symbol(sym_type sym);
      return (int'(sym) == SYMBOL_COUNT - 1);
   endfunction

   function automatic logic is_term_symbol(sym_type sym);
      return (int'(sym) == TERM_SYMBOL);
   endfunction

endpackage

// ===== hdl/static_huffman_byte_decoder.sv =====
// static huffman byte decoder: each byte walks the fixed tree one bit per cycle
// while the held symbol and output register let it step; bytes after end of stream
// are dropped unwalked; a result goes via the hold register to the output register;
// the last result of a byte is held until the byte's final bit or terminator
// reset (synchronous, active high) empties the queue, returns the walk to the root
// and clears the end-of-stream flag; the node table is constant and needs no fill
module static_huffman_byte_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [shbd_pkg::REQ_TDATA_W-1:0]    req_tdata,  // data_byte
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [shbd_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // symbol, char_code
   output logic                                rsp_tuser,  // end_of_stream
   output logic                                rsp_tlast
);

   shbd_pkg::queue_head_type          head;
   logic                              pop;
   logic                              stream_done;
   logic [shbd_pkg::SYMBOL_W-1:0]     rsp_symbol;
   logic [shbd_pkg::CHAR_W-1:0]       rsp_char_code;

   shbd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_data_byte (req_tdata[shbd_pkg::BYTE_W-1:0]),
      .pop           (pop),
      .stream_done   (stream_done),
      .head          (head)
   );

   shbd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .pop               (pop),
      .stream_done       (stream_done),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_symbol        (rsp_symbol),
      .rsp_char_code     (rsp_char_code),
      .rsp_end_of_stream (rsp_tuser),
      .rsp_last          (rsp_tlast)
   );

   assign rsp_tdata = {{shbd_pkg::RSP_PAD_W{1'b0}}, rsp_char_code, rsp_symbol};

endmodule

// ===== hdl/shbd_front.sv =====
// front part: accepts compressed bytes into a short queue for the tree walker
// bytes after end of stream are dropped here
// depends on shbd_pkg
module shbd_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [shbd_pkg::BYTE_W-1:0]       req_data_byte,
   input  logic                              pop,
   input  logic                              stream_done,
   output shbd_pkg::queue_head_type          head
);

   logic [shbd_pkg::BYTE_W-1:0] queue_ff [shbd_pkg::QUEUE_DEPTH];
   logic [shbd_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [shbd_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [shbd_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                        push;
   logic                        do_pop;

   assign req_tready = stream_done || (count_ff != shbd_pkg::QCNT_W'(shbd_pkg::QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready && !stream_done;
   assign do_pop     = pop && head.valid;

   assign head.valid     = (count_ff != '0);
   assign head.data_byte = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) count_in = count_ff + 1'b1;
      if (!push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) queue_ff[wr_ptr_ff] <= req_data_byte;
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= shbd_pkg::QCNT_W'(shbd_pkg::QUEUE_DEPTH))
      else $error("queue fill beyond depth");

endmodule

// ===== hdl/shbd_back.sv =====
// back part: bit-serial walk through the constant huffman node table
// one held symbol waits until the next leaf or the byte end decides its last flag
// depends on shbd_pkg
module shbd_back (
   input  logic                              clock,
   input  logic                              reset,
   input  shbd_pkg::queue_head_type          head,
   output logic                              pop,
   output logic                              stream_done,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [shbd_pkg::SYMBOL_W-1:0]     rsp_symbol,
   output logic [shbd_pkg::CHAR_W-1:0]       rsp_char_code,
   output logic                              rsp_end_of_stream,
   output logic                              rsp_last
);

   logic                           busy_ff, busy_in;
   logic [shbd_pkg::BYTE_W-1:0]    byte_ff, byte_in;
   logic [shbd_pkg::BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [shbd_pkg::NODE_W-1:0]    pos_ff, pos_in;
   logic                           done_ff, done_in;
   logic                           hold_valid_ff, hold_valid_in;
   logic                           hold_closed_ff, hold_closed_in;
   shbd_pkg::sym_type              hold_sym_ff, hold_sym_in;
   logic                           out_valid_ff, out_valid_in;
   logic [shbd_pkg::SYMBOL_W-1:0]  out_sym_ff, out_sym_in;
   logic [shbd_pkg::CHAR_W-1:0]    out_char_ff, out_char_in;
   logic                           out_end_ff, out_end_in;
   logic                           out_last_ff, out_last_in;

   logic [2*shbd_pkg::CODE_W-1:0]  node;
   logic [shbd_pkg::CODE_W-1:0]    child;
   logic                           leaf;
   shbd_pkg::sym_type              leaf_sym;
   logic                           byte_end;
   logic                           out_free;
   logic                           step;
   logic                           flush;
   logic                           move_out;

   assign node     = shbd_pkg::NODE_TABLE[pos_ff];
   assign child    = byte_ff[shbd_pkg::BYTE_W-1] ? node[2*shbd_pkg::CODE_W-1:shbd_pkg::CODE_W]
                                                 : node[shbd_pkg::CODE_W-1:0];
   assign leaf     = child[shbd_pkg::CODE_W-1];
   assign leaf_sym = child[shbd_pkg::SYM_W-1:0];
   assign byte_end = (bit_cnt_ff == '0) || (leaf && shbd_pkg::is_term_symbol(leaf_sym));
   assign out_free = !out_valid_ff || rsp_tready;

   // a closed hold leaves with a step, which waits for a free output; an open one only when a new leaf comes
   assign step     = busy_ff && (!hold_valid_ff ||
                                 (hold_closed_ff ? out_free : (!leaf || out_free)));
   assign flush    = !step && hold_valid_ff && hold_closed_ff && out_free;
   assign move_out = flush || (step && hold_valid_ff && (hold_closed_ff || leaf));
   assign pop      = head.valid && (!busy_ff || (step && byte_end));

   always_comb begin
      done_in        = done_ff;
      pos_in         = pos_ff;
      hold_valid_in  = hold_valid_ff;
      hold_closed_in = hold_closed_ff;
      hold_sym_in    = hold_sym_ff;
      busy_in        = busy_ff;
      byte_in        = byte_ff;
      bit_cnt_in     = bit_cnt_ff;
      out_valid_in   = out_valid_ff && !rsp_tready;
      out_sym_in     = out_sym_ff;
      out_char_in    = out_char_ff;
      out_end_in     = out_end_ff;
      out_last_in    = out_last_ff;

      if (move_out) begin
         out_valid_in  = 1'b1;
         out_sym_in    = shbd_pkg::SYMBOL_W'(hold_sym_ff);
         out_char_in   = shbd_pkg::char_of(hold_sym_ff);
         out_end_in    = shbd_pkg::is_end_symbol(hold_sym_ff);
         out_last_in   = hold_closed_ff;
         hold_valid_in = 1'b0;
      end

      if (step) begin
         byte_in    = {byte_ff[shbd_pkg::BYTE_W-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff - 1'b1;
         if (leaf) begin
            pos_in         = shbd_pkg::ROOT_NODE;
            hold_valid_in  = 1'b1;
            hold_sym_in    = leaf_sym;
            hold_closed_in = byte_end;
            if (shbd_pkg::is_end_symbol(leaf_sym)) done_in = 1'b1;
         end else begin
            pos_in = child[shbd_pkg::NODE_W-1:0];
            if (byte_end) hold_closed_in = 1'b1;
         end
         if (byte_end) busy_in = 1'b0;
      end

      // bytes that arrive after end of stream are discarded at the queue head
      if (pop) begin
         busy_in    = !done_in;
         byte_in    = head.data_byte;
         bit_cnt_in = shbd_pkg::BIT_CNT_W'(shbd_pkg::BYTE_W - 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         pos_ff        <= shbd_pkg::ROOT_NODE;
         done_ff       <= 1'b0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         pos_ff        <= pos_in;
         done_ff       <= done_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      hold_closed_ff <= hold_closed_in;
      hold_sym_ff    <= hold_sym_in;
      byte_ff        <= byte_in;
      bit_cnt_ff     <= bit_cnt_in;
      out_sym_ff     <= out_sym_in;
      out_char_ff    <= out_char_in;
      out_end_ff     <= out_end_in;
      out_last_ff    <= out_last_in;
   end

   assign stream_done       = done_ff;
   assign rsp_tvalid        = out_valid_ff;
   assign rsp_symbol        = out_sym_ff;
   assign rsp_char_code     = out_char_ff;
   assign rsp_end_of_stream = out_end_ff;
   assign rsp_last          = out_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      move_out |-> out_free)
      else $error("held symbol overwrote a pending result");

   assert property (@(posedge clock) disable iff (reset)
      pos_ff <= shbd_pkg::ROOT_NODE)
      else $error("walk position outside the inner nodes");

   assert property (@(posedge clock) disable iff (reset)
      (done_ff && !busy_ff) |=> !busy_ff)
      else $error("byte walked after end of stream");

   assert property (@(posedge clock) disable iff (reset)
      done_ff |=> done_ff)
      else $error("end of stream flag cleared");

endmodule

// ===== dv/tb_static_huffman_byte_decoder.sv =====
// testbench for the static huffman byte decoder: directed and random compressed bytes,
// each decoded symbol checked against a tree walk rebuilt here from the frequency table
// depends on shbd_pkg (port widths) and static_huffman_byte_decoder
module tb_static_huffman_byte_decoder;

   localparam int LEAF_COUNT      = 31;
   localparam int INNER_COUNT     = LEAF_COUNT - 1;
   localparam logic [4:0] ROOT_NODE = 5'(INNER_COUNT - 1);
   localparam logic [7:0] LEAF_FLAG = 8'h80;
   localparam int SYM_LAST_LETTER = 25;
   localparam int SYM_SPACE       = 26;
   localparam int SYM_TERM        = 27;
   localparam int SYM_NEWLINE     = 28;
   localparam int SYM_BACKQUOTE   = 29;
   localparam int SYM_END         = 30;
   localparam int CHAR_LETTER_A   = 97;
   localparam int CHAR_SPACE      = 32;
   localparam int CHAR_NEWLINE    = 10;
   localparam int CHAR_BACKQUOTE  = 96;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int HOLD_CYCLES     = 400;
   localparam int SETTLE_CYCLES   = 16;
   localparam int RANDOM_PER_PHASE = 150;

   localparam int SYMBOL_FREQ [LEAF_COUNT] = '{
      81, 15, 28, 43, 128, 23, 20, 61, 71, 2, 1, 40, 24, 69, 76, 20,
      1, 61, 64, 91, 28, 10, 24, 1, 20, 1, 130, 80, 80, 5, 80
   };

   typedef enum int {FIND_TERMINATOR, FIND_SILENT, FIND_BUSIEST} byte_search_type;

   typedef struct packed {
      logic [4:0] symbol;
      logic [7:0] char_code;
      logic       end_of_stream;
      logic       last;
   } decoded_symbol_type;

   typedef struct packed {
      logic [3:0]                 count;
      decoded_symbol_type [7:0]   outs;
      logic [4:0]                 pos;
      logic                       done;
      logic                       hits_end;
   } byte_walk_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [shbd_pkg::REQ_TDATA_W-1:0] req_tdata = '0;   // data_byte
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [shbd_pkg::RSP_TDATA_W-1:0] rsp_tdata;        // symbol, char_code
   logic rsp_tuser;                                    // end_of_stream
   logic rsp_tlast;

   logic [7:0] left_child  [INNER_COUNT];
   logic [7:0] right_child [INNER_COUNT];

   logic [7:0]         pending_bytes [$];
   decoded_symbol_type expected_symbols [$];
   logic [4:0] gen_pos = ROOT_NODE;
   logic       gen_done = 1'b0;
   logic [4:0] model_pos;
   logic       model_done;
   logic       req_fire = 1'b0;
   int         mismatch_count = 0;
   int         req_idle_pct = 0;
   int         rsp_stall_pct = 0;
   int         hold_request = 0;
   int         hold_seen = 0;
   int         hold_left = 0;
   int         stall_cycles = 0;

   static_huffman_byte_decoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic logic [7:0] char_for(int sym);
      if (sym <= SYM_LAST_LETTER) return 8'(CHAR_LETTER_A + sym);
      if (sym == SYM_SPACE) return 8'(CHAR_SPACE);
      if (sym == SYM_NEWLINE) return 8'(CHAR_NEWLINE);
      if (sym == SYM_BACKQUOTE) return 8'(CHAR_BACKQUOTE);
      return 8'h00;
   endfunction

   // one byte through the tree, msb first, from the given walk state
   function automatic byte_walk_type walk_byte(logic [7:0] data, logic [4:0] pos_in,
                                               logic done_in);
      byte_walk_type      w;
      decoded_symbol_type s;
      logic [7:0]         child;
      int                 sym;
      logic               stop;
      w = '0;
      w.pos = pos_in;
      w.done = done_in;
      stop = 1'b0;
      if (!done_in) begin
         for (int bit_i = 7; bit_i >= 0; bit_i--) begin
            if (!stop) begin
               if (w.pos >= INNER_COUNT) w.pos = ROOT_NODE;
               child = data[bit_i] ? right_child[w.pos] : left_child[w.pos];
               if ((child & LEAF_FLAG) != 0) begin
                  sym = int'(child[6:0]);
                  s.symbol = 5'(sym);
                  s.char_code = char_for(sym);
                  s.end_of_stream = (sym == SYM_END);
                  s.last = 1'b0;
                  w.outs[w.count] = s;
                  w.count = w.count + 4'd1;
                  w.pos = ROOT_NODE;
                  if (sym == SYM_END) begin
                     w.done = 1'b1;
                     w.hits_end = 1'b1;
                  end
                  // terminator drops the rest of the byte
                  if (sym == SYM_TERM) stop = 1'b1;
               end else begin
                  w.pos = child[4:0];
               end
            end
         end
      end
      if (w.count != 0) w.outs[w.count - 4'd1].last = 1'b1;
      return w;
   endfunction

   task automatic queue_byte(input logic [7:0] data);
      byte_walk_type w;
      w = walk_byte(data, gen_pos, gen_done);
      gen_pos = w.pos;
      gen_done = w.done;
      pending_bytes.push_back(data);
   endtask

   task automatic queue_random(input int count, input bit allow_end);
      byte_walk_type w;
      logic [7:0]    cand;
      int            tries;
      for (int i = 0; i < count; i++) begin
         tries = 0;
         do begin
            cand = 8'($urandom_range(255));
            w = walk_byte(cand, gen_pos, gen_done);
            tries++;
         end while (!allow_end && w.hits_end && tries < 1000);
         queue_byte(cand);
      end
   endtask

   // a fixed pattern, unless it would close the stream too early
   task automatic queue_directed(input logic [7:0] data);
      byte_walk_type w;
      w = walk_byte(data, gen_pos, gen_done);
      if (w.hits_end) queue_random(1, 1'b0);
      else queue_byte(data);
   endtask

   task automatic queue_found(input byte_search_type kind);
      byte_walk_type w;
      int            pick;
      int            most;
      bit            has_term;
      pick = -1;
      most = -1;
      for (int c = 0; c < 256; c++) begin
         w = walk_byte(8'(c), gen_pos, gen_done);
         has_term = 1'b0;
         for (int r = 0; r < 8; r++) begin
            if (r < w.count && w.outs[r].symbol == 5'(SYM_TERM)) has_term = 1'b1;
         end
         if (!w.hits_end) begin
            case (kind)
               FIND_TERMINATOR: if (has_term && pick < 0) pick = c;
               FIND_SILENT:     if (w.count == 0 && pick < 0) pick = c;
               FIND_BUSIEST:    if (int'(w.count) > most) begin
                  most = int'(w.count);
                  pick = c;
               end
               default: ;
            endcase
         end
      end
      if (pick >= 0) queue_byte(8'(pick));
   endtask

   task automatic wait_for_drain();
      while (pending_bytes.size() != 0 || req_tvalid || expected_symbols.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // sender
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (pending_bytes.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_bytes.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver, with a long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_seen != hold_request) begin
         hold_seen <= hold_request;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // prediction on each byte transfer, checking on each symbol transfer
   always @(posedge clock) begin
      byte_walk_type      w;
      decoded_symbol_type want;
      if (reset) begin
         req_fire <= 1'b0;
         model_pos = ROOT_NODE;
         model_done = 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            w = walk_byte(req_tdata, model_pos, model_done);
            model_pos = w.pos;
            model_done = w.done;
            for (int r = 0; r < 8; r++) begin
               if (r < w.count) expected_symbols.push_back(w.outs[r]);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_symbols.size() == 0) begin
               $error("symbol transfer with nothing expected: tdata %h", rsp_tdata);
               mismatch_count++;
            end else begin
               want = expected_symbols.pop_front();
               if (rsp_tdata[4:0] !== want.symbol) begin
                  $error("symbol: expected %0d, actual %0d", want.symbol, rsp_tdata[4:0]);
                  mismatch_count++;
               end
               if (rsp_tdata[12:5] !== want.char_code) begin
                  $error("char_code: expected %0d, actual %0d", want.char_code,
                         rsp_tdata[12:5]);
                  mismatch_count++;
               end
               if (rsp_tuser !== want.end_of_stream) begin
                  $error("end_of_stream: expected %0b, actual %0b", want.end_of_stream,
                         rsp_tuser);
                  mismatch_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last: expected %0b, actual %0b", want.last, rsp_tlast);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int pool_code [LEAF_COUNT];
      int pool_freq [LEAF_COUNT];
      int pick_code [2];
      int pick_freq [2];
      int pool_len;
      int best;
      int tail_count;

      // fixed tree: first strict minimum twice, left then right, parent at the head
      for (int i = 0; i < LEAF_COUNT; i++) begin
         pool_code[i] = int'(LEAF_FLAG) | i;
         pool_freq[i] = SYMBOL_FREQ[i];
      end
      pool_len = LEAF_COUNT;
      for (int k = 0; k < INNER_COUNT; k++) begin
         for (int p = 0; p < 2; p++) begin
            best = 0;
            for (int j = 1; j < pool_len; j++) begin
               if (pool_freq[j] < pool_freq[best]) best = j;
            end
            pick_code[p] = pool_code[best];
            pick_freq[p] = pool_freq[best];
            for (int j = best; j < pool_len - 1; j++) begin
               pool_code[j] = pool_code[j+1];
               pool_freq[j] = pool_freq[j+1];
            end
            pool_len--;
         end
         for (int j = pool_len; j > 0; j--) begin
            pool_code[j] = pool_code[j-1];
            pool_freq[j] = pool_freq[j-1];
         end
         pool_code[0] = k;
         pool_freq[0] = pick_freq[0] + pick_freq[1];
         pool_len++;
         left_child[k] = 8'(pick_code[0]);
         right_child[k] = 8'(pick_code[1]);
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      req_idle_pct = 26;
      rsp_stall_pct = 74;
      queue_directed(8'h00);
      queue_directed(8'hFF);
      queue_directed(8'h80);
      queue_directed(8'h7F);
      queue_directed(8'h01);
      queue_directed(8'hFE);
      queue_found(FIND_TERMINATOR);
      queue_directed(8'h55);
      queue_directed(8'hAA);
      queue_found(FIND_SILENT);
      queue_found(FIND_BUSIEST);
      queue_found(FIND_TERMINATOR);
      queue_found(FIND_SILENT);
      queue_found(FIND_BUSIEST);
      queue_directed(8'h0F);
      queue_directed(8'hF0);
      queue_directed(8'hC3);
      queue_directed(8'h3C);
      queue_random(RANDOM_PER_PHASE, 1'b0);
      wait_for_drain();

      req_idle_pct = 74;
      rsp_stall_pct = 26;
      queue_random(RANDOM_PER_PHASE, 1'b0);
      wait_for_drain();

      req_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_request++;
      queue_random(RANDOM_PER_PHASE, 1'b0);
      wait_for_drain();

      // end of stream, then bytes that must be ignored
      tail_count = 0;
      while (!gen_done && tail_count < 200) begin
         queue_random(1, 1'b1);
         tail_count++;
      end
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_random(3, 1'b1);
      wait_for_drain();

      if (expected_symbols.size() != 0) begin
         $error("%0d expected symbols never arrived", expected_symbols.size());
      end
      if (mismatch_count == 0 && expected_symbols.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
